// File: rtl/mcwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcwt_pkg: shared definitions for the multi-client watchdog table
// field widths, command codes, result codes and the stored entry layout
// ----------------------------------------------------------------------------
package mcwt_pkg;

  localparam int ENTRIES_DEF    = 8;
  localparam int NAME_BYTES_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 64;
  localparam int REASON_W = 8;
  localparam int PERIOD_W = 16;

  // command codes on func
  localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNREGISTER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_KICK       = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd3;

  // result codes
  localparam logic KIND_STATUS    = 1'b0;
  localparam logic KIND_REPORT    = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // one table entry as held in memory
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [REASON_W-1:0] reason;
    logic                active;
    logic                kicked;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: rtl/mcwt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcwt_ram: generic simple dual-port ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module mcwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/multi_client_watchdog_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_client_watchdog_table: software watchdog shared by many clients
// register, unregister and kick scan every entry and give their status word
//   from the finish state; an expiring tick reports during the scan and gives
//   its last report from the finish state
// a scan holds busy, so no new start is taken, while it reads every entry
//   through the single read port of the entry memory, waits for the registered
//   read data and finishes; non-expiring ticks and bad-key commands stay in idle
// results are strobed for one cycle and cannot be stalled
// reset: per-entry valid flops clear at once, no clearing pass is needed
// ----------------------------------------------------------------------------
module multi_client_watchdog_table #(
  parameter int ENTRIES    = mcwt_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = mcwt_pkg::NAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: report_enable
  input  logic                          cfg_write,
  input  logic                          cfg_data,
  // command word
  input  logic                          start,
  output logic                          busy,
  input  logic [mcwt_pkg::FUNC_W-1:0]   func,
  input  logic [mcwt_pkg::KEY_W-1:0]    name_key,
  input  logic [mcwt_pkg::REASON_W-1:0] reason,
  input  logic [mcwt_pkg::PERIOD_W-1:0] period_seconds,
  // result word
  output logic                          strobe,
  output logic                          kind,
  output logic                          status,
  output logic [mcwt_pkg::REASON_W-1:0] reported_reason,
  output logic                          last
);

  import mcwt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // keys with bits above the name bytes do not fit a name
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * NAME_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // latched command
  logic [FUNC_W-1:0]   cmd_func;
  logic [KEY_W-1:0]    cmd_key;
  logic [REASON_W-1:0] cmd_reason;
  logic [PERIOD_W-1:0] cmd_period;

  // scan pipeline: issue read at rd_cnt, evaluate in the next cycle
  logic [IDX_W:0]      rd_cnt;
  logic                eval_vld;
  logic [IDX_W-1:0]    eval_idx;
  logic                rd_vld;
  logic [ENTRIES-1:0]  valid;

  // scan results for commands
  logic                found_match;
  logic [IDX_W-1:0]    match_idx;
  entry_t              match_ent;
  logic                found_free;
  logic [IDX_W-1:0]    free_idx;

  // held-back report so the final one can carry last
  logic                pend;
  logic [REASON_W-1:0] pend_reason;

  // timer and configuration
  logic [PERIOD_W-1:0] period_length;
  logic [PERIOD_W-1:0] countdown;
  logic                timer_running;
  logic                report_enable;

  // memory ports
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;

  entry_t              ent;
  logic                key_ok;
  logic                ent_match;
  logic                ent_free;
  logic                ent_missed;
  logic [PERIOD_W-1:0] cd_dec;
  logic                cmd_ok;

  mcwt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  // entries never written read as free
  assign ent        = rd_vld ? entry_t'(ram_rdata) : '0;
  assign ent_match  = (ent.key != '0) && (ent.key == cmd_key);
  assign ent_free   = (ent.key == '0);
  assign ent_missed = ent.active && !ent.kicked && report_enable;

  assign key_ok = (name_key != '0) && ((name_key & ~KEY_MASK) == '0);
  assign cd_dec = (countdown != '0) ? (countdown - 1'b1) : countdown;

  assign ram_re    = (state == S_SCAN) && (rd_cnt < (IDX_W + 1)'(ENTRIES));
  assign ram_raddr = rd_cnt[IDX_W-1:0];

  // register needs a matching or free entry, the others a matching one
  assign cmd_ok = (cmd_func == FUNC_REGISTER) ? (found_match || found_free) : found_match;

  // write-back: tick clears kick marks during the scan, commands write at the end
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = eval_idx;
    ram_wdata = ent;
    if (state == S_SCAN && eval_vld && cmd_func == FUNC_TICK) begin
      ram_we           = 1'b1;
      ram_wdata.kicked = 1'b0;
    end else if (state == S_FINISH) begin
      ram_waddr = found_match ? match_idx : free_idx;
      case (cmd_func)
        FUNC_REGISTER: begin
          ram_we           = found_match || found_free;
          ram_wdata.key    = cmd_key;
          ram_wdata.reason = cmd_reason;
          ram_wdata.active = 1'b1;
          ram_wdata.kicked = 1'b0;
        end
        FUNC_UNREGISTER: begin
          ram_we    = found_match;
          ram_wdata = '0;
        end
        FUNC_KICK: begin
          ram_we           = found_match;
          ram_wdata        = match_ent;
          ram_wdata.kicked = 1'b1;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_enable <= 1'b0;
    end else if (cfg_write) begin
      report_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_cnt        <= '0;
      eval_vld      <= 1'b0;
      found_match   <= 1'b0;
      found_free    <= 1'b0;
      pend          <= 1'b0;
      period_length <= '0;
      countdown     <= '0;
      timer_running <= 1'b0;
      strobe        <= 1'b0;
      kind          <= KIND_STATUS;
      status        <= STATUS_OK;
      last          <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_func    <= func;
            cmd_key     <= name_key;
            cmd_reason  <= reason;
            cmd_period  <= period_seconds;
            rd_cnt      <= '0;
            eval_vld    <= 1'b0;
            found_match <= 1'b0;
            found_free  <= 1'b0;
            pend        <= 1'b0;
            if (func == FUNC_TICK) begin
              // stopped timer ignores ticks; only expiry starts a scan
              if (timer_running) begin
                if (cd_dec != '0) begin
                  countdown <= cd_dec;
                end else begin
                  countdown <= period_length;
                  state     <= S_SCAN;
                end
              end
            end else if (!key_ok) begin
              // empty or overlong key: reject without touching the table
              strobe          <= 1'b1;
              kind            <= KIND_STATUS;
              status          <= STATUS_INVALID;
              reported_reason <= '0;
              last            <= 1'b0;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          rd_vld   <= valid[ram_raddr];
          eval_vld <= ram_re;
          eval_idx <= ram_raddr;
          if (ram_re) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (eval_vld) begin
            if (cmd_func == FUNC_TICK) begin
              if (ent_missed) begin
                if (pend) begin
                  strobe          <= 1'b1;
                  kind            <= KIND_REPORT;
                  status          <= STATUS_OK;
                  reported_reason <= pend_reason;
                  last            <= 1'b0;
                end
                pend        <= 1'b1;
                pend_reason <= ent.reason;
              end
            end else begin
              // first matching key and first free entry, in table order
              if (!found_match && ent_match) begin
                found_match <= 1'b1;
                match_idx   <= eval_idx;
                match_ent   <= ent;
              end
              if (!found_free && ent_free) begin
                found_free <= 1'b1;
                free_idx   <= eval_idx;
              end
            end
            if (eval_idx == IDX_W'(ENTRIES - 1)) begin
              state <= S_FINISH;
            end
          end
        end

        S_FINISH: begin
          state <= S_IDLE;
          if (cmd_func == FUNC_TICK) begin
            if (pend) begin
              strobe          <= 1'b1;
              kind            <= KIND_REPORT;
              status          <= STATUS_OK;
              reported_reason <= pend_reason;
              last            <= 1'b1;
            end
          end else begin
            strobe          <= 1'b1;
            kind            <= KIND_STATUS;
            status          <= cmd_ok ? STATUS_OK : STATUS_INVALID;
            reported_reason <= '0;
            last            <= 1'b0;
            // a longer period grows the timer and restarts the countdown
            if (cmd_func == FUNC_REGISTER && cmd_ok && cmd_period > period_length) begin
              period_length <= cmd_period;
              countdown     <= cmd_period;
              timer_running <= 1'b1;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: test/tb_multi_client_watchdog_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_client_watchdog_table: self-checking bench for the watchdog table
// drives register, unregister, kick and one-second tick words through the
// start/busy handshake, predicts every status and missed-kick report with an
// in-bench copy of the table, and compares each strobed result word in order
// ----------------------------------------------------------------------------
module tb_multi_client_watchdog_table;
  import mcwt_pkg::*;

  localparam int ENTRIES        = ENTRIES_DEF;
  localparam int NAME_BYTES     = NAME_BYTES_DEF;
  // covers a full scan of every entry and the finish state, plus a margin
  localparam int SETTLE_CYCLES  = ENTRIES + 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTED   = 10;
  localparam int KEY_POOL       = 12;
  // longest period used while expiry is still being exercised
  localparam int PERIOD_CAP     = 6;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (NAME_BYTES >= 8) ? '1 : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

  // one result word as seen on the output ports
  typedef struct packed {
    logic                kind;
    logic                status;
    logic [REASON_W-1:0] rsn;
    logic                last;
  } result_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic                cfg_data = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   func = FUNC_REGISTER;
  logic [KEY_W-1:0]    name_key = '0;
  logic [REASON_W-1:0] reason = '0;
  logic [PERIOD_W-1:0] period_seconds = '0;
  logic                strobe;
  logic                kind;
  logic                status;
  logic [REASON_W-1:0] reported_reason;
  logic                last;

  // words the table is expected to produce, oldest first
  result_word_t expected_words[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  // bench copy of the watchdog table
  logic [KEY_W-1:0]    tbl_key    [ENTRIES];
  logic                tbl_active [ENTRIES];
  logic                tbl_kicked [ENTRIES];
  logic [REASON_W-1:0] tbl_reason [ENTRIES];
  logic [PERIOD_W-1:0] wd_period;
  logic [PERIOD_W-1:0] wd_countdown;
  logic                wd_running;
  logic                rep_en;

  // client names used by the traffic, a small pool so the table fills up
  logic [KEY_W-1:0]    key_pool [KEY_POOL];

  multi_client_watchdog_table #(
    .ENTRIES    (ENTRIES),
    .NAME_BYTES (NAME_BYTES)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .name_key        (name_key),
    .reason          (reason),
    .period_seconds  (period_seconds),
    .strobe          (strobe),
    .kind            (kind),
    .status          (status),
    .reported_reason (reported_reason),
    .last            (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // table predictor
  // ------------------------------------------------------------------------
  function automatic void clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_key[i]    = '0;
      tbl_active[i] = 1'b0;
      tbl_kicked[i] = 1'b0;
      tbl_reason[i] = '0;
    end
    wd_period    = '0;
    wd_countdown = '0;
    wd_running   = 1'b0;
    rep_en       = 1'b0;
  endfunction

  // key 0 marks a free entry, so it never matches
  function automatic int find_client(input logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_key[i] != '0 && tbl_key[i] == k)
        return i;
    return -1;
  endfunction

  function automatic void predict_word(input logic [FUNC_W-1:0] f,
                                       input logic [KEY_W-1:0] k,
                                       input logic [REASON_W-1:0] r,
                                       input logic [PERIOD_W-1:0] p);
    int           slot;
    int           misses;
    int           n;
    logic         ok;
    result_word_t w;
    if (f == FUNC_TICK) begin
      // stopped timer: ticks do nothing
      if (!wd_running)
        return;
      if (wd_countdown != '0)
        wd_countdown = wd_countdown - 1'b1;
      if (wd_countdown != '0)
        return;
      // expiry: report every active entry that missed its kick, if reporting is enabled
      misses = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (tbl_active[i] && !tbl_kicked[i] && rep_en)
          misses++;
      n = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_active[i] && !tbl_kicked[i] && rep_en) begin
          n++;
          w.kind   = KIND_REPORT;
          w.status = STATUS_OK;
          w.rsn    = tbl_reason[i];
          w.last   = (n == misses);
          expected_words.push_back(w);
        end
        tbl_kicked[i] = 1'b0;
      end
      wd_countdown = wd_period;
      return;
    end
    ok = 1'b0;
    // empty or overlong names are rejected by every command
    if (k != '0 && (k & ~KEY_MASK) == '0) begin
      slot = find_client(k);
      if (f == FUNC_REGISTER) begin
        if (slot < 0)
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && tbl_key[i] == '0)
              slot = i;
        if (slot >= 0) begin
          ok               = 1'b1;
          tbl_key[slot]    = k;
          tbl_reason[slot] = r;
          tbl_active[slot] = 1'b1;
          tbl_kicked[slot] = 1'b0;
          // only a longer period restarts the countdown
          if (p > wd_period) begin
            wd_period    = p;
            wd_countdown = p;
            wd_running   = 1'b1;
          end
        end
      end else if (slot >= 0) begin
        ok = 1'b1;
        if (f == FUNC_UNREGISTER) begin
          tbl_key[slot]    = '0;
          tbl_active[slot] = 1'b0;
          tbl_kicked[slot] = 1'b0;
        end else begin
          tbl_kicked[slot] = 1'b1;
        end
      end
    end
    w.kind   = KIND_STATUS;
    w.status = ok ? STATUS_OK : STATUS_INVALID;
    w.rsn    = '0;
    w.last   = 1'b0;
    expected_words.push_back(w);
  endfunction

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input result_word_t want,
                               input result_word_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTED)
      $display("%0t %s: expected kind=%0d status=%0d reason=%0d last=%0d, %s",
               $time, what, want.kind, want.status, want.rsn, want.last,
               $sformatf("got kind=%0d status=%0d reason=%0d last=%0d",
                         got.kind, got.status, got.rsn, got.last));
  endtask

  // results cannot be held off, so every strobe is taken at once
  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst && strobe) begin
      got = {kind, status, reported_reason, last};
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want)
          note_mismatch("word mismatch", want, got);
      end
    end
  end

  // stall watchdog: ends the run if nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps)
      return 0;
    r = $urandom_range(0, 19);
    if (r < 10)
      return 0;
    if (r < 17)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly a period no longer than the current one, sometimes one longer while under the cap
  function automatic logic [PERIOD_W-1:0] next_period();
    if (wd_period < PERIOD_CAP && $urandom_range(0, 9) == 0)
      return wd_period + 1'b1;
    return PERIOD_W'($urandom_range(0, wd_period));
  endfunction

  // drive one command word and hold it until the block takes it;
  // start is left high when the next word follows with no gap
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                           input logic [REASON_W-1:0] r,
                           input logic [PERIOD_W-1:0] p);
    int gap;
    start          <= 1'b1;
    func           <= f;
    name_key       <= k;
    reason         <= r;
    period_seconds <= p;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    predict_word(f, k, r, p);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all expected words, then let a scan with no result finish
  task automatic settle_block();
    start <= 1'b0;
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_report_enable(input logic v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    rep_en = v;
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  // empty name, unknown names and a tick while the timer is stopped
  task automatic test_bad_names();
    send_word(FUNC_REGISTER, '0, 8'hFF, 16'hFFFF);
    send_word(FUNC_UNREGISTER, '0, 8'h00, 16'h0000);
    send_word(FUNC_KICK, '0, 8'h5A, 16'h1234);
    send_word(FUNC_UNREGISTER, key_pool[3], 8'hFF, 16'hFFFF);
    send_word(FUNC_KICK, key_pool[5], 8'h00, 16'h0000);
    // tick fields are ignored
    send_word(FUNC_TICK, '1, 8'hFF, 16'hFFFF);
  endtask

  // fill every entry, overflow by one, then re-register with equal period
  task automatic test_full_table();
    send_word(FUNC_REGISTER, key_pool[0], 8'hFF, 16'd0);
    send_word(FUNC_REGISTER, key_pool[1], 8'h00, 16'd2);
    for (int i = 2; i < ENTRIES; i++)
      send_word(FUNC_REGISTER, key_pool[i], REASON_W'($urandom_range(0, 255)), 16'd1);
    send_word(FUNC_REGISTER, key_pool[ENTRIES], 8'h3C, 16'd1);
    send_word(FUNC_REGISTER, key_pool[1], 8'h81, 16'd2);
  endtask

  // partial kicks, a scan where the unkicked entries miss, then one where every entry misses
  task automatic test_expiry();
    settle_block();
    write_report_enable(1'b1);
    send_word(FUNC_KICK, key_pool[0], 8'hFF, 16'hFFFF);
    send_word(FUNC_KICK, key_pool[2], 8'h00, 16'h0000);
    send_word(FUNC_KICK, key_pool[4], 8'h00, 16'h0000);
    send_word(FUNC_TICK, '0, 8'h00, 16'h0000);
    send_word(FUNC_TICK, '0, 8'h00, 16'h0000);
    send_word(FUNC_TICK, KEY_W'($urandom), 8'h00, 16'h0000);
    send_word(FUNC_TICK, KEY_W'($urandom), 8'h00, 16'h0000);
    send_word(FUNC_UNREGISTER, key_pool[3], 8'hFF, 16'hFFFF);
  endtask

  // mostly valid traffic on the key pool with some rejected words mixed in
  task automatic test_random_traffic(input int n_words);
    int                  pick;
    logic [FUNC_W-1:0]   f;
    logic [KEY_W-1:0]    k;
    logic [REASON_W-1:0] r;
    logic [PERIOD_W-1:0] p;
    for (int n = 0; n < n_words; n++) begin
      // switch between idling and back-to-back stretches
      if (n % 25 == 0)
        no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      k    = key_pool[$urandom_range(0, KEY_POOL - 1)];
      r    = REASON_W'($urandom_range(0, 255));
      p    = PERIOD_W'($urandom);
      if (pick < 25) begin
        f = FUNC_REGISTER;
        p = next_period();
      end else if (pick < 35) begin
        f = FUNC_UNREGISTER;
      end else if (pick < 60) begin
        f = FUNC_KICK;
      end else if (pick < 95) begin
        f = FUNC_TICK;
        k = {$urandom, $urandom};
      end else begin
        // empty name or a name never registered
        f = pick[0] ? FUNC_KICK : (pick[1] ? FUNC_UNREGISTER : FUNC_REGISTER);
        k = $urandom_range(0, 1) ? '0 : {$urandom, $urandom};
        if (f == FUNC_REGISTER)
          p = next_period();
      end
      send_word(f, k, r, p);
    end
    no_gaps = 1'b0;
  endtask

  // longest period last: afterwards no register can grow it any more
  task automatic test_long_period();
    send_word(FUNC_REGISTER, key_pool[1], 8'hA5, 16'hFFFF);
    for (int n = 0; n < 8; n++) begin
      if (n % 2 == 0)
        send_word(FUNC_REGISTER, key_pool[$urandom_range(0, KEY_POOL - 1)],
                  REASON_W'($urandom_range(0, 255)), PERIOD_W'($urandom));
      else
        send_word(FUNC_TICK, {$urandom, $urandom}, REASON_W'($urandom_range(0, 255)),
                  PERIOD_W'($urandom));
    end
  endtask

  initial begin
    clear_table();
    key_pool[0] = '1;
    key_pool[1] = 64'd1;
    for (int i = 2; i < KEY_POOL; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i] == '0)
        key_pool[i] = 64'd2;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bad_names();
    test_full_table();
    test_expiry();
    test_random_traffic(110);
    settle_block();
    write_report_enable(1'b0);
    test_random_traffic(110);
    settle_block();
    write_report_enable(1'b1);
    test_random_traffic(110);
    test_long_period();
    settle_block();

    // anything still waiting never arrived
    mismatches = mismatches + expected_words.size();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
